// ===== hw/rtl/gkd_pkg.sv =====
// Shared types, constants and constant tables of the kernel density block.
package gkd_pkg;

  localparam int MAX_KERNELS    = 256;
  localparam int MAX_DIM        = 16;
  localparam int EXP_TABLE_SIZE = 256;
  localparam int CUTOFF_M       = 20;

  localparam int KN_W      = $clog2(MAX_KERNELS);
  localparam int EL_W      = $clog2(MAX_DIM);
  localparam int NK_W      = KN_W + 1;
  localparam int ND_W      = EL_W + 1;
  localparam int SLOT_W    = $clog2(EXP_TABLE_SIZE);
  localparam int EXP_W     = 12;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int CFG_W     = NK_W;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;

  localparam logic CFG_KERNEL_COUNT = 1'b0;
  localparam logic CFG_VECTOR_DIM   = 1'b1;

  typedef enum logic [1:0] {
    FUNC_CENTRE = 2'd0,
    FUNC_WIDTH  = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR_ACC, OP_W_CAP, OP_SQ, OP_ACC, OP_WSQ, OP_LIM,
    OP_SLOT_INIT, OP_SLOT_STEP, OP_NL_W, OP_NSTEP, OP_ST_XPW, OP_MUL,
    OP_ST_PW, OP_TAB, OP_DIV_INIT, OP_DIV_STEP, OP_NL_Q, OP_ST_TERM,
    OP_ST_RES, OP_CPY_ACC, OP_ADD, OP_ST_ACC, OP_LD_RTP, OP_NL_NK,
    OP_ST_X, OP_RES_ZERO, OP_OUT_LD
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_W_CHK, S_SQ, S_ACC, S_WSQ, S_LIM, S_CUT, S_SLOT,
    S_WN_LD, S_WN_RUN, S_PMUL, S_PM_RUN, S_TAB, S_DIV_INIT, S_DIV,
    S_Q_LD, S_Q_RUN, S_ADD, S_A_RUN, S_K_NEXT, S_FIN, S_NK_LD, S_NK_RUN,
    S_DMUL, S_DM_RUN, S_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e            op;
    logic              accept;
    logic              fin;
    logic [KN_W-1:0]   rd_kn;
    logic [EL_W-1:0]   rd_el;
    logic [NK_W-1:0]   nk;
    logic [ND_W-1:0]   nd;
  } dp_cmd_t;

  typedef struct packed {
    logic w_bad;
    logic cut;
    logic nrm_done;
    logic acc_zero;
  } dp_sts_t;

  typedef logic [31:0]             exp_mant_t [EXP_TABLE_SIZE];
  typedef logic signed [EXP_W-1:0] exp_e_t    [EXP_TABLE_SIZE];

  function automatic int msb64(input logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = i;
    end
    return p;
  endfunction

  // Raw exp(-10*t/size) entries in Q1.31, built by repeated multiplication.
  function automatic exp_mant_t exp_raw_tab();
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r32;
    exp_mant_t   tab;
    term = 64'd1 << 60;
    pos  = term;
    neg  = 64'd0;
    for (int kk = 1; kk < 40; kk++) begin
      if (term != 64'd0) begin
        term = (term * 64'd10) / 64'(EXP_TABLE_SIZE * kk);
        if ((kk & 1) == 1) neg = neg + term;
        else pos = pos + term;
      end
    end
    r32 = ((pos - neg) + (64'd1 << 27)) >> 28;
    tab[0] = 32'h8000_0000;
    for (int kk = 1; kk < EXP_TABLE_SIZE; kk++) begin
      tab[kk] = 32'(((64'(tab[kk-1]) * r32) + (64'd1 << 31)) >> 32);
    end
    return tab;
  endfunction

  function automatic exp_mant_t exp_mant_tab();
    exp_mant_t raw;
    exp_mant_t tab;
    int        p;
    raw = exp_raw_tab();
    for (int t = 0; t < EXP_TABLE_SIZE; t++) begin
      p      = msb64(64'(raw[t]));
      tab[t] = raw[t] << (31 - p);
    end
    return tab;
  endfunction

  function automatic exp_e_t exp_e_tab();
    exp_mant_t raw;
    exp_e_t    tab;
    raw = exp_raw_tab();
    for (int t = 0; t < EXP_TABLE_SIZE; t++) begin
      tab[t] = EXP_W'(msb64(64'(raw[t])) - 31);
    end
    return tab;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bt;
    rem  = v;
    root = 64'd0;
    bt   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > rem) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (rem >= root + bt) begin
          rem  = rem - (root + bt);
          root = (root >> 1) + bt;
        end else begin
          root = root >> 1;
        end
        bt = bt >> 2;
      end
    end
    return root;
  endfunction

  function automatic logic [31:0] rtp_mant();
    logic [63:0] r;
    int          p;
    r = isqrt64(TWO_PI_Q60);
    p = msb64(r);
    if (p > 31) return 32'(r >> (p - 31));
    else return 32'(r << (31 - p));
  endfunction

  function automatic logic signed [EXP_W-1:0] rtp_exp();
    return EXP_W'(msb64(isqrt64(TWO_PI_Q60)) - 30);
  endfunction

  localparam exp_mant_t EXP_MANT = exp_mant_tab();
  localparam exp_e_t    EXP_E    = exp_e_tab();

  localparam logic [31:0]             RTP_M = rtp_mant();
  localparam logic signed [EXP_W-1:0] RTP_E = rtp_exp();

endpackage

// ===== hw/rtl/gkd_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
module gkd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gkd_dp.sv =====
// Datapath: kernel and query stores, distance, slot divider, soft-float unit, result register.
module gkd_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gkd_pkg::dp_cmd_t  cmd_i,
  output gkd_pkg::dp_sts_t  sts_o,
  input  logic [1:0]        in_func_i,
  input  logic [7:0]        in_kn_i,
  input  logic [3:0]        in_el_i,
  input  logic [15:0]       in_data_i,
  output logic [39:0]       out_data_o,
  output logic              out_zero_o
);

  import gkd_pkg::*;

  logic        c_we;
  logic        w_we;
  logic        q_we;
  logic [15:0] c_rd;
  logic [15:0] w_rd;
  logic [15:0] q_rd;

  logic [15:0] w_q;
  logic [31:0] sq_q;
  logic [35:0] ssd_q;
  logic [29:0] wsq_q;
  logic [34:0] lim_q;
  logic [34:0] rem_q;
  logic [SLOT_W-1:0] slot_q;

  logic [63:0]             nv_q;
  logic signed [EXP_W-1:0] ne_q;
  logic [31:0]             x_m_q, pw_m_q, acc_m_q, t_m_q;
  logic signed [EXP_W-1:0] x_e_q, pw_e_q, acc_e_q, t_e_q;

  logic [63:0]             dq_q;
  logic [31:0]             dr_q;
  logic [31:0]             db_q;
  logic signed [EXP_W-1:0] de_q;

  logic [31:0]             res_m_q;
  logic [7:0]              res_e_q;
  logic                    res_z_q;
  logic [31:0]             out_m_q;
  logic [7:0]              out_e_q;
  logic                    out_z_q;

  logic signed [16:0]      df;
  logic [16:0]             ad;
  logic [35:0]             r2;
  logic [32:0]             dsh;
  logic                    nv_zero;
  logic [31:0]             st_m;
  logic signed [EXP_W-1:0] st_e;
  logic                    swap;
  logic [31:0]             am, bm;
  logic signed [EXP_W-1:0] ae, be, dd;
  logic [63:0]             lo;
  logic [63:0]             prod;

  assign c_we = cmd_i.accept && (in_func_i == FUNC_CENTRE);
  assign w_we = cmd_i.accept && (in_func_i == FUNC_WIDTH);
  assign q_we = cmd_i.accept && (in_func_i == FUNC_QUERY);

  gkd_ram #(.WIDTH(16), .DEPTH(MAX_KERNELS * MAX_DIM)) u_centre (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i ({in_kn_i, in_el_i}),
    .wdata_i (in_data_i),
    .raddr_i ({cmd_i.rd_kn, cmd_i.rd_el}),
    .rdata_o (c_rd)
  );

  gkd_ram #(.WIDTH(16), .DEPTH(MAX_KERNELS)) u_width (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (in_kn_i),
    .wdata_i (in_data_i),
    .raddr_i (cmd_i.rd_kn),
    .rdata_o (w_rd)
  );

  gkd_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_query (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (in_el_i),
    .wdata_i (in_data_i),
    .raddr_i (cmd_i.rd_el),
    .rdata_o (q_rd)
  );

  always_comb begin
    df      = 17'($signed(q_rd)) - 17'($signed(c_rd));
    ad      = df[16] ? 17'(-df) : 17'(df);
    r2      = {rem_q, 1'b0};
    dsh     = {dr_q, dq_q[63]};
    nv_zero = (nv_q == 64'd0);
    st_m    = nv_zero ? 32'd0 : nv_q[63:32];
    st_e    = nv_zero ? '0 : ne_q;
    swap    = t_e_q > acc_e_q;
    am      = swap ? t_m_q : acc_m_q;
    ae      = swap ? t_e_q : acc_e_q;
    bm      = swap ? acc_m_q : t_m_q;
    be      = swap ? acc_e_q : t_e_q;
    dd      = ae - be;
    lo      = (dd > EXP_W'(63)) ? 64'd0 : ({1'b0, bm, 31'd0} >> dd[5:0]);
    prod    = pw_m_q * x_m_q;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CLR_ACC: begin
        acc_m_q <= 32'd0;
        acc_e_q <= '0;
      end
      OP_W_CAP: begin
        w_q   <= w_rd;
        ssd_q <= 36'd0;
      end
      OP_SQ:        sq_q  <= ad[15:0] * ad[15:0];
      OP_ACC:       ssd_q <= ssd_q + 36'(sq_q);
      OP_WSQ:       wsq_q <= w_q[14:0] * w_q[14:0];
      OP_LIM:       lim_q <= 35'(wsq_q) * 35'(CUTOFF_M);
      OP_SLOT_INIT: begin
        rem_q  <= ssd_q[34:0];
        slot_q <= '0;
      end
      OP_SLOT_STEP: begin
        if (r2 >= {1'b0, lim_q}) begin
          rem_q  <= 35'(r2 - {1'b0, lim_q});
          slot_q <= {slot_q[SLOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= r2[34:0];
          slot_q <= {slot_q[SLOT_W-2:0], 1'b0};
        end
      end
      OP_NL_W: begin
        nv_q <= {48'd0, w_q};
        ne_q <= EXP_W'(63);
      end
      OP_NL_NK: begin
        nv_q <= 64'(cmd_i.nk);
        ne_q <= EXP_W'(63);
      end
      OP_NSTEP: begin
        if (!nv_zero && !nv_q[63]) begin
          if (nv_q[63:56] == 8'd0) begin
            nv_q <= nv_q << 8;
            ne_q <= ne_q - EXP_W'(8);
          end else begin
            nv_q <= nv_q << 1;
            ne_q <= ne_q - EXP_W'(1);
          end
        end
      end
      OP_ST_XPW: begin
        x_m_q  <= st_m;
        x_e_q  <= st_e;
        pw_m_q <= st_m;
        pw_e_q <= st_e;
      end
      OP_MUL: begin
        // Product of two normalized mantissas; the normalizer takes it next.
        nv_q <= prod;
        ne_q <= pw_e_q + x_e_q + EXP_W'(1);
      end
      OP_ST_PW: begin
        pw_m_q <= st_m;
        pw_e_q <= st_e;
      end
      OP_ST_X: begin
        x_m_q <= st_m;
        x_e_q <= st_e;
      end
      OP_TAB: begin
        t_m_q <= EXP_MANT[slot_q];
        t_e_q <= EXP_E[slot_q];
      end
      OP_DIV_INIT: begin
        dq_q <= {(cmd_i.fin ? acc_m_q : t_m_q), 32'd0};
        dr_q <= 32'd0;
        db_q <= pw_m_q;
        de_q <= (cmd_i.fin ? acc_e_q : t_e_q) - pw_e_q - EXP_W'(32);
      end
      OP_DIV_STEP: begin
        if (dsh >= {1'b0, db_q}) begin
          dr_q <= 32'(dsh - {1'b0, db_q});
          dq_q <= {dq_q[62:0], 1'b1};
        end else begin
          dr_q <= dsh[31:0];
          dq_q <= {dq_q[62:0], 1'b0};
        end
      end
      OP_NL_Q: begin
        nv_q <= dq_q;
        ne_q <= de_q + EXP_W'(63);
      end
      OP_ST_TERM: begin
        t_m_q <= st_m;
        t_e_q <= st_e + EXP_W'({cmd_i.nd, 3'b000});
      end
      OP_ST_RES: begin
        res_z_q <= 1'b0;
        if (st_e > EXP_W'(127)) begin
          res_m_q <= 32'hFFFF_FFFF;
          res_e_q <= 8'd127;
        end else if (st_e < -EXP_W'(128)) begin
          res_m_q <= 32'd0;
          res_e_q <= 8'd0;
        end else begin
          res_m_q <= st_m;
          res_e_q <= st_e[7:0];
        end
      end
      OP_RES_ZERO: begin
        res_m_q <= 32'd0;
        res_e_q <= 8'd0;
        res_z_q <= 1'b1;
      end
      OP_CPY_ACC: begin
        acc_m_q <= t_m_q;
        acc_e_q <= t_e_q;
      end
      OP_ADD: begin
        nv_q <= {1'b0, am, 31'd0} + lo;
        ne_q <= ae + EXP_W'(1);
      end
      OP_ST_ACC: begin
        acc_m_q <= st_m;
        acc_e_q <= st_e;
      end
      OP_LD_RTP: begin
        pw_m_q <= RTP_M;
        pw_e_q <= RTP_E;
        x_m_q  <= RTP_M;
        x_e_q  <= RTP_E;
      end
      OP_OUT_LD: begin
        out_m_q <= res_m_q;
        out_e_q <= res_e_q;
        out_z_q <= res_z_q;
      end
      default: ;
    endcase
  end

  // The reset only affects the width status flag, which reads as bad while reset is held.
  logic unused_rst;
  assign unused_rst = rst_ni;

  assign sts_o.w_bad    = w_rd[15] || (w_rd == 16'd0) || !unused_rst;
  assign sts_o.cut      = ssd_q >= {1'b0, lim_q};
  assign sts_o.nrm_done = nv_zero || nv_q[63];
  assign sts_o.acc_zero = (acc_m_q == 32'd0);

  assign out_data_o = {out_e_q, out_m_q};
  assign out_zero_o = out_z_q;

endmodule

// ===== hw/rtl/gkd_ctrl.sv =====
// Controller: handshakes, configuration registers, loop counters and sequencer.
module gkd_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [gkd_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                     s_tvalid_i,
  input  logic [1:0]               s_func_i,
  input  logic                     s_last_i,
  output logic                     s_tready_o,
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output gkd_pkg::dp_cmd_t         cmd_o,
  input  gkd_pkg::dp_sts_t         sts_i
);

  import gkd_pkg::*;

  ctrl_state_e     state_q, state_d;
  logic [NK_W-1:0] kc_q;
  logic [ND_W-1:0] vd_q;
  logic [KN_W-1:0] kn_q, kn_d;
  logic [EL_W-1:0] el_q, el_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic            fin_q, fin_d;
  logic            ov_q, ov_d;
  logic [NK_W-1:0] nk;
  logic [ND_W-1:0] nd;
  logic [NK_W-1:0] nk_m1;
  logic [ND_W-1:0] nd_m1;
  logic            el_last, kn_last, nd_one, start, out_free;
  dp_op_e          op;

  always_comb begin
    if (kc_q == '0) nk = NK_W'(1);
    else if (kc_q > NK_W'(MAX_KERNELS)) nk = NK_W'(MAX_KERNELS);
    else nk = kc_q;
    if (vd_q == '0) nd = ND_W'(1);
    else if (vd_q > ND_W'(MAX_DIM)) nd = ND_W'(MAX_DIM);
    else nd = vd_q;
    nk_m1    = nk - NK_W'(1);
    nd_m1    = nd - ND_W'(1);
    el_last  = (el_q == nd_m1[EL_W-1:0]);
    kn_last  = (kn_q == nk_m1[KN_W-1:0]);
    nd_one   = (nd == ND_W'(1));
    start    = s_tvalid_i && (s_func_i == FUNC_QUERY) && s_last_i;
    out_free = !ov_q || m_tready_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (start) state_d = S_INIT;
      S_INIT:     state_d = S_W_CHK;
      S_W_CHK:    state_d = sts_i.w_bad ? S_K_NEXT : S_SQ;
      S_SQ:       state_d = S_ACC;
      S_ACC:      state_d = el_last ? S_WSQ : S_SQ;
      S_WSQ:      state_d = S_LIM;
      S_LIM:      state_d = S_CUT;
      S_CUT:      state_d = sts_i.cut ? S_K_NEXT : S_SLOT;
      S_SLOT:     if (cnt_q == CNT_W'(SLOT_W - 1)) state_d = S_WN_LD;
      S_WN_LD:    state_d = S_WN_RUN;
      S_WN_RUN:   if (sts_i.nrm_done) state_d = nd_one ? S_TAB : S_PMUL;
      S_PMUL:     state_d = S_PM_RUN;
      S_PM_RUN: begin
        if (sts_i.nrm_done) begin
          if (!el_last) state_d = S_PMUL;
          else state_d = fin_q ? S_NK_LD : S_TAB;
        end
      end
      S_TAB:      state_d = S_DIV_INIT;
      S_DIV_INIT: state_d = S_DIV;
      S_DIV:      if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_Q_LD;
      S_Q_LD:     state_d = S_Q_RUN;
      S_Q_RUN:    if (sts_i.nrm_done) state_d = fin_q ? S_OUT : S_ADD;
      S_ADD:      state_d = sts_i.acc_zero ? S_K_NEXT : S_A_RUN;
      S_A_RUN:    if (sts_i.nrm_done) state_d = S_K_NEXT;
      S_K_NEXT:   state_d = kn_last ? S_FIN : S_W_CHK;
      S_FIN: begin
        if (sts_i.acc_zero) state_d = S_OUT;
        else state_d = nd_one ? S_NK_LD : S_PMUL;
      end
      S_NK_LD:    state_d = S_NK_RUN;
      S_NK_RUN:   if (sts_i.nrm_done) state_d = S_DMUL;
      S_DMUL:     state_d = S_DM_RUN;
      S_DM_RUN:   if (sts_i.nrm_done) state_d = S_DIV_INIT;
      S_OUT:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op    = OP_NONE;
    kn_d  = kn_q;
    el_d  = el_q;
    cnt_d = cnt_q;
    fin_d = fin_q;
    ov_d  = ov_q && !m_tready_i;
    case (state_q)
      S_IDLE: ;
      S_INIT: begin
        op    = OP_CLR_ACC;
        kn_d  = '0;
        el_d  = '0;
        fin_d = 1'b0;
      end
      S_W_CHK:  if (!sts_i.w_bad) op = OP_W_CAP;
      S_SQ:     op = OP_SQ;
      S_ACC: begin
        op = OP_ACC;
        if (!el_last) el_d = el_q + EL_W'(1);
      end
      S_WSQ:    op = OP_WSQ;
      S_LIM:    op = OP_LIM;
      S_CUT: begin
        if (!sts_i.cut) begin
          op    = OP_SLOT_INIT;
          cnt_d = '0;
        end
      end
      S_SLOT: begin
        op    = OP_SLOT_STEP;
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_WN_LD:  op = OP_NL_W;
      S_WN_RUN: begin
        if (sts_i.nrm_done) begin
          op   = OP_ST_XPW;
          el_d = EL_W'(1);
        end else begin
          op = OP_NSTEP;
        end
      end
      S_PMUL, S_DMUL: op = OP_MUL;
      S_PM_RUN: begin
        if (sts_i.nrm_done) begin
          op = OP_ST_PW;
          if (!el_last) el_d = el_q + EL_W'(1);
        end else begin
          op = OP_NSTEP;
        end
      end
      S_TAB:    op = OP_TAB;
      S_DIV_INIT: begin
        op    = OP_DIV_INIT;
        cnt_d = '0;
      end
      S_DIV: begin
        op    = OP_DIV_STEP;
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_Q_LD:   op = OP_NL_Q;
      S_Q_RUN: begin
        if (sts_i.nrm_done) op = fin_q ? OP_ST_RES : OP_ST_TERM;
        else op = OP_NSTEP;
      end
      S_ADD:    op = sts_i.acc_zero ? OP_CPY_ACC : OP_ADD;
      S_A_RUN:  op = sts_i.nrm_done ? OP_ST_ACC : OP_NSTEP;
      S_K_NEXT: begin
        if (!kn_last) begin
          kn_d = kn_q + KN_W'(1);
          el_d = '0;
        end
      end
      S_FIN: begin
        if (sts_i.acc_zero) begin
          op = OP_RES_ZERO;
        end else begin
          op    = OP_LD_RTP;
          el_d  = EL_W'(1);
          fin_d = 1'b1;
        end
      end
      S_NK_LD:  op = OP_NL_NK;
      S_NK_RUN: op = sts_i.nrm_done ? OP_ST_X : OP_NSTEP;
      S_DM_RUN: op = sts_i.nrm_done ? OP_ST_PW : OP_NSTEP;
      S_OUT: begin
        if (out_free) begin
          op   = OP_OUT_LD;
          ov_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kc_q    <= NK_W'(1);
      vd_q    <= ND_W'(1);
      kn_q    <= '0;
      el_q    <= '0;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      kn_q    <= kn_d;
      el_q    <= el_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_KERNEL_COUNT) kc_q <= cfg_data_i;
        else if (cfg_idx_i == CFG_VECTOR_DIM) vd_q <= cfg_data_i[ND_W-1:0];
      end
    end
  end

  assign s_tready_o   = (state_q == S_IDLE);
  assign m_tvalid_o   = ov_q;
  assign cmd_o.op     = op;
  assign cmd_o.accept = s_tvalid_i && (state_q == S_IDLE);
  assign cmd_o.fin    = fin_q;
  assign cmd_o.rd_kn  = kn_d;
  assign cmd_o.rd_el  = el_d;
  assign cmd_o.nk     = nk;
  assign cmd_o.nd     = nd;

endmodule

// ===== hw/rtl/gaussian_kernel_density_top.sv =====
// Top level of the Gaussian kernel density estimator.
//
//   channel   dir   handshake          payload
//   s_*       in    tvalid / tready    tdata: kernel_index, element_index, data_value
//                                      tuser: func, tlast: last_element
//   m_*       out   tvalid / tready    tdata: density_mantissa, density_exponent
//                                      tuser: zero_density
//   cfg_*     in    cfg_we_i           cfg_idx_i selects the register, cfg_data_i
//
// A load item or a query item that is not last only writes its store. A last
// query element starts an evaluation that walks the kernels one after another
// on a shared soft-float unit. A kernel inside the cutoff takes the distance
// over every element, the width power over every extra element, and a division
// on the 64-step bit-serial divider. A kernel outside the cutoff stops after
// the cutoff check, and one whose width is not positive is skipped. A final
// division by the kernel count times sqrt(2*pi)^dim closes the evaluation.
// The input is not ready during an evaluation, nor while a finished one waits
// for the output register to free up. The result sits in an output register,
// so the next items are accepted while it waits for m_tready_i. Reset is
// asynchronous and active low; it clears the sequencer and sets both
// configuration registers to one. The stores are not cleared by reset.
module gaussian_kernel_density_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port.
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [gkd_pkg::CFG_W-1:0] cfg_data_i,
  // Input items.
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  // [7:0] kernel_index, [11:8] element_index, [27:12] data_value, [31:28] zero.
  input  logic [31:0]               s_tdata_i,
  // [1:0] func.
  input  logic [1:0]                s_tuser_i,
  input  logic                      s_tlast_i,
  // Result items.
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  // [31:0] density_mantissa, [39:32] density_exponent.
  output logic [39:0]               m_tdata_o,
  // [0] zero_density.
  output logic [0:0]                m_tuser_o
);

  import gkd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    out_zero;

  // The sequencer owns the handshakes and configuration; it drives the
  // datapath one operation per cycle and reads back a few status flags.
  gkd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_func_i   (s_tuser_i),
    .s_last_i   (s_tlast_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Centre, width and query stores live in the datapath, next to the
  // distance, slot and soft-float arithmetic that reads them.
  gkd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_func_i  (s_tuser_i),
    .in_kn_i    (s_tdata_i[7:0]),
    .in_el_i    (s_tdata_i[11:8]),
    .in_data_i  (s_tdata_i[27:12]),
    .out_data_o (m_tdata_o),
    .out_zero_o (out_zero)
  );

  assign m_tuser_o = out_zero;

endmodule

// ===== test/gaussian_kernel_density_top_test.sv =====
// Self-checking testbench for the Gaussian kernel density estimator top level.
`timescale 1ns / 100ps

module gaussian_kernel_density_top_test;
  import gkd_pkg::*;

  // Idle cycles with no accepted item on either side before the run is abandoned.
  // The slowest evaluation here walks 256 kernels, and the receiver holds off
  // once for HOLD_CYCLES, so this is a generous multiple of both.
  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 400;

  // Soft float value: mantissa with the top bit set (or zero), value m*2^(e-31).
  typedef struct {
    logic [31:0] m;
    int          e;
  } sfloat_t;

  typedef struct {
    logic [31:0] mant;
    logic [7:0]  expo;
    logic        zero;
  } density_t;

  // Scoreboard: keeps its own copy of the stores and registers, works out the
  // density for every evaluating query item and checks results in order.
  class density_scoreboard;
    logic signed [15:0] centre [MAX_KERNELS][MAX_DIM];
    logic signed [15:0] width [MAX_KERNELS];
    logic signed [15:0] query [MAX_DIM];
    int unsigned        kcount_reg;
    int unsigned        dim_reg;
    logic [31:0]        exp_rom [EXP_TABLE_SIZE];
    sfloat_t            root_2pi;
    density_t           pending_q[$];
    int                 errors;
    int                 results_seen;
    int                 queries_seen;
    int                 zero_seen;
    int                 sat_seen;

    function new();
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] r32;
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bt;
      term = 64'd1 << 60;
      pos = term;
      neg = 64'd0;
      for (int kk = 1; kk < 40; kk++) begin
        if (term != 64'd0) begin
          term = (term * 64'd10) / (64'(EXP_TABLE_SIZE) * 64'(kk));
          if (kk % 2 == 1) neg += term;
          else pos += term;
        end
      end
      r32 = ((pos - neg) + (64'd1 << 27)) >> 28;
      exp_rom[0] = 32'h8000_0000;
      for (int kk = 1; kk < EXP_TABLE_SIZE; kk++) begin
        exp_rom[kk] = 32'(((64'(exp_rom[kk-1]) * r32) + (64'd1 << 31)) >> 32);
      end
      // Integer square root of 2*pi in Q4.60 gives sqrt(2*pi) in Q.30.
      rem = TWO_PI_Q60;
      root = 64'd0;
      bt = 64'd1 << 62;
      while (bt > rem) bt = bt >> 2;
      while (bt != 64'd0) begin
        if (rem >= root + bt) begin
          rem = rem - (root + bt);
          root = (root >> 1) + bt;
        end else begin
          root = root >> 1;
        end
        bt = bt >> 2;
      end
      root_2pi = normalize(root, -30);
      kcount_reg = 1;
      dim_reg = 1;
      errors = 0;
      results_seen = 0;
      queries_seen = 0;
      zero_seen = 0;
      sat_seen = 0;
    endfunction

    function sfloat_t normalize(logic [63:0] v, int sh);
      sfloat_t r;
      int      p;
      r.m = 32'd0;
      r.e = 0;
      if (v == 64'd0) return r;
      p = 63;
      while (v[p] == 1'b0) p--;
      if (p > 31) r.m = 32'(v >> (p - 31));
      else r.m = 32'(v << (31 - p));
      r.e = sh + p;
      return r;
    endfunction

    function sfloat_t fmul(sfloat_t a, sfloat_t b);
      sfloat_t z;
      z.m = 32'd0;
      z.e = 0;
      if (a.m == 0 || b.m == 0) return z;
      return normalize(64'(a.m) * 64'(b.m), a.e + b.e - 62);
    endfunction

    function sfloat_t fdiv(sfloat_t a, sfloat_t b);
      sfloat_t z;
      z.m = 32'd0;
      z.e = 0;
      if (a.m == 0 || b.m == 0) return z;
      return normalize((64'(a.m) << 32) / 64'(b.m), a.e - b.e - 32);
    endfunction

    function sfloat_t fadd(sfloat_t a, sfloat_t b);
      sfloat_t     t;
      logic [63:0] hi;
      logic [63:0] lo;
      int          d;
      if (a.m == 0) return b;
      if (b.m == 0) return a;
      if (b.e > a.e) begin
        t = a;
        a = b;
        b = t;
      end
      d = a.e - b.e;
      hi = 64'(a.m) << 31;
      lo = (d >= 64) ? 64'd0 : ((64'(b.m) << 31) >> d);
      return normalize(hi + lo, a.e - 62);
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_KERNEL_COUNT) kcount_reg = value;
      else dim_reg = value[4:0];
    endfunction

    function density_t density_of_query();
      int unsigned nk;
      int unsigned nd;
      int          wr;
      int          df;
      logic [63:0] ad;
      logic [63:0] ssd;
      logic [63:0] lim;
      logic [63:0] slot;
      sfloat_t     acc;
      sfloat_t     wpow;
      sfloat_t     term;
      sfloat_t     den;
      density_t    d;
      nk = kcount_reg;
      nd = dim_reg;
      if (nk < 1) nk = 1;
      if (nk > MAX_KERNELS) nk = MAX_KERNELS;
      if (nd < 1) nd = 1;
      if (nd > MAX_DIM) nd = MAX_DIM;
      acc.m = 32'd0;
      acc.e = 0;
      for (int k = 0; k < nk; k++) begin
        wr = width[k];
        if (wr > 0) begin
          ssd = 64'd0;
          for (int e = 0; e < nd; e++) begin
            df = int'(query[e]) - int'(centre[k][e]);
            ad = 64'(df < 0 ? -df : df);
            ssd += ad * ad;
          end
          lim = 64'(wr) * 64'(wr) * 64'(CUTOFF_M);
          if (ssd < lim) begin
            slot = (ssd * 64'(EXP_TABLE_SIZE)) / lim;
            if (slot >= EXP_TABLE_SIZE) slot = EXP_TABLE_SIZE - 1;
            wpow = normalize(64'(wr), 0);
            for (int e = 1; e < nd; e++) wpow = fmul(wpow, normalize(64'(wr), 0));
            term = fdiv(normalize(64'(exp_rom[slot]), -31), wpow);
            term.e += 8 * nd;
            acc = fadd(acc, term);
          end
        end
      end
      d.zero = 1'b0;
      if (acc.m == 0) begin
        d.mant = 32'd0;
        d.expo = 8'd0;
        d.zero = 1'b1;
        return d;
      end
      den = root_2pi;
      for (int e = 1; e < nd; e++) den = fmul(den, root_2pi);
      den = fmul(den, normalize(64'(nk), 0));
      acc = fdiv(acc, den);
      if (acc.e > 127) begin
        acc.m = 32'hFFFF_FFFF;
        acc.e = 127;
      end else if (acc.e < -128) begin
        acc.m = 32'd0;
        acc.e = 0;
      end
      d.mant = acc.m;
      d.expo = 8'(acc.e);
      return d;
    endfunction

    // Called for every accepted input item.
    function void note_item(func_e f, logic [7:0] kn, logic [3:0] el,
                            logic [15:0] v, logic last);
      density_t d;
      case (f)
        FUNC_CENTRE: begin
          centre[kn][el] = v;
        end
        FUNC_WIDTH: begin
          width[kn] = v;
        end
        FUNC_QUERY: begin
          query[el] = v;
          if (last) begin
            d = density_of_query();
            if (d.zero) zero_seen++;
            if (d.expo == 8'd127 && d.mant == 32'hFFFF_FFFF) sat_seen++;
            pending_q.push_back(d);
            queries_seen++;
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Called for every accepted result item.
    function void check_result(logic [31:0] mant, logic [7:0] expo, logic zero);
      density_t d;
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result mant=%h exp=%h zero=%b",
                                   mant, expo, zero);
        return;
      end
      d = pending_q.pop_front();
      if (d.mant !== mant || d.expo !== expo || d.zero !== zero) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d expected mant=%h exp=%h zero=%b, got mant=%h exp=%h zero=%b",
                   results_seen, d.mant, d.expo, d.zero, mant, expo, zero);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_tvalid_i;
  logic                 s_tready_o;
  logic [31:0]          s_tdata_i;
  logic [1:0]           s_tuser_i;
  logic                 s_tlast_i;
  logic                 m_tvalid_o;
  logic                 m_tready_i;
  logic [39:0]          m_tdata_o;
  logic [0:0]           m_tuser_o;

  gaussian_kernel_density_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  density_scoreboard sb;

  // Which store entries have been written; evaluations may only read those.
  bit centre_ok [MAX_KERNELS][MAX_DIM];
  bit width_ok [MAX_KERNELS];
  bit query_ok [MAX_DIM];

  int unsigned active_nk;
  int unsigned active_nd;
  int          burst_left;
  int          items_sent;
  int          idle_cycles;
  bit          hold_request;
  int          phases_run;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // All inputs start known; reset is held from the start and released once.
  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_KERNEL_COUNT;
    cfg_data_i <= '0;
    s_tvalid_i <= 1'b0;
    s_tdata_i <= '0;
    s_tuser_i <= FUNC_NONE;
    s_tlast_i <= 1'b0;
    m_tready_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver side. Ready follows a pattern that is re-picked at random:
  // always ready, random stalls, or a fixed one-in-five stall. On request
  // it holds off for HOLD_CYCLES so the output register and then the input
  // side back up behind it.
  initial begin
    int mode;
    int cnt;
    mode = 0;
    cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        cnt++;
        if (cnt % 200 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: m_tready_i <= 1'b1;
          1: m_tready_i <= ($urandom_range(0, 9) < 7);
          default: m_tready_i <= (cnt % 5 != 0);
        endcase
      end
    end
  end

  // Handshakes are sampled at the falling edge, where every signal is stable
  // until the rising edge that completes the transfer. Result items are checked
  // here; the watchdog counts cycles in which neither side moves an item.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        sb.check_result(m_tdata_o[31:0], m_tdata_o[39:32], m_tuser_o[0]);
      end
      if ((m_tvalid_o && m_tready_i) || (s_tvalid_i && s_tready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("ERROR: no item moved for %0d cycles, %0d results still due",
                   IDLE_LIMIT, sb.pending_q.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Sends one input item; the sender works in bursts with random gaps between.
  // Returns at the rising edge at which the item was accepted.
  task automatic send_item(func_e f, logic [7:0] kn, logic [3:0] el,
                           logic [15:0] v, logic last);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {4'b0000, v, el, kn};
    s_tuser_i <= f;
    s_tlast_i <= last;
    do @(negedge clk_i); while (!s_tready_o);
    @(posedge clk_i);
    sb.note_item(f, kn, el, v, last);
    items_sent++;
    case (f)
      FUNC_CENTRE: centre_ok[kn][el] = 1'b1;
      FUNC_WIDTH:  width_ok[kn] = 1'b1;
      FUNC_QUERY:  query_ok[el] = 1'b1;
      default: begin
      end
    endcase
  endtask

  // Element values: mostly near zero so kernels fall inside the cutoff,
  // sometimes anywhere in the full signed range.
  function automatic logic [15:0] element_value();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  function automatic logic [15:0] width_value();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'(16'h8000 | $urandom);
      2: return 16'($urandom);
      default: return 16'($urandom_range(128, 4096));
    endcase
  endfunction

  // Writes every store entry that the next evaluation will read and that has
  // never been written, so no evaluation touches undefined contents.
  task automatic fill_gaps();
    for (int k = 0; k < active_nk; k++) begin
      if (!width_ok[k]) send_item(FUNC_WIDTH, 8'(k), 4'($urandom), width_value(), 1'b0);
      if (sb.width[k] > 0) begin
        for (int e = 0; e < active_nd; e++) begin
          if (!centre_ok[k][e]) send_item(FUNC_CENTRE, 8'(k), 4'(e), element_value(), 1'b0);
        end
      end
    end
    for (int e = 0; e < active_nd; e++) begin
      if (!query_ok[e]) send_item(FUNC_QUERY, 8'($urandom), 4'(e), element_value(), 1'b0);
    end
  endtask

  task automatic query_item(logic [3:0] el, logic [15:0] v, logic last);
    if (last) fill_gaps();
    send_item(FUNC_QUERY, 8'($urandom), el, v, last);
  endtask

  // Stops offering items and waits for every expected result, then lets the
  // block settle before registers may be written.
  task automatic drain();
    s_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // New register setting; the block clamps the kernel count and dimension
  // when it uses them, and the generator uses the clamped values.
  task automatic start_phase(logic [CFG_W-1:0] nk_raw, logic [4:0] nd_raw);
    drain();
    write_cfg(CFG_KERNEL_COUNT, nk_raw);
    write_cfg(CFG_VECTOR_DIM, CFG_W'(nd_raw));
    active_nk = nk_raw == 0 ? 1 : (nk_raw > MAX_KERNELS ? MAX_KERNELS : nk_raw);
    active_nd = nd_raw == 0 ? 1 : (nd_raw > MAX_DIM ? MAX_DIM : nd_raw);
    phases_run++;
  endtask

  // Random traffic: mostly whole query vectors with random content, mixed with
  // loads aimed mostly at the kernels in use, stray items and ignored noise.
  task automatic random_traffic(int count);
    int    stop_at;
    int    pick;
    int    k;
    logic  last;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, active_nk - 1);
      case (pick)
        0, 1, 2, 3, 4, 5: begin
          for (int e = 0; e < active_nd; e++) begin
            query_item(4'(e), element_value(), e == active_nd - 1);
          end
        end
        6: send_item(FUNC_CENTRE, 8'(k), 4'($urandom), element_value(), 1'($urandom));
        7: send_item(FUNC_WIDTH, 8'(k), 4'($urandom), width_value(), 1'($urandom));
        8: send_item(FUNC_NONE, 8'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
        default: begin
          last = 1'($urandom);
          query_item(4'($urandom), element_value(), last);
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    items_sent = 0;
    idle_cycles = 0;
    hold_request = 1'b0;
    phases_run = 0;
    active_nk = 1;
    active_nd = 1;
    @(posedge rst_ni);
    @(posedge clk_i);

    // One kernel, one dimension: peak density, zero density, extreme values,
    // skipped widths and ignored items.
    start_phase(CFG_W'(1), 5'd1);
    send_item(FUNC_WIDTH, 8'd0, 4'd0, 16'h0100, 1'b0);
    send_item(FUNC_CENTRE, 8'd0, 4'd0, 16'h0000, 1'b0);
    send_item(FUNC_QUERY, 8'd0, 4'd0, 16'h0000, 1'b1);
    send_item(FUNC_QUERY, 8'd0, 4'd0, 16'h7FFF, 1'b1);
    send_item(FUNC_CENTRE, 8'd0, 4'd0, 16'h8000, 1'b0);
    send_item(FUNC_WIDTH, 8'd0, 4'd0, 16'h7FFF, 1'b0);
    send_item(FUNC_QUERY, 8'd0, 4'd0, 16'h7FFF, 1'b1);
    send_item(FUNC_WIDTH, 8'd0, 4'd0, 16'h0000, 1'b0);
    send_item(FUNC_QUERY, 8'd0, 4'd0, 16'h8000, 1'b1);
    send_item(FUNC_WIDTH, 8'd0, 4'd0, 16'hFFFB, 1'b0);
    send_item(FUNC_QUERY, 8'd0, 4'd0, 16'h8000, 1'b1);
    send_item(FUNC_WIDTH, 8'd0, 4'd0, 16'h0001, 1'b1);
    send_item(FUNC_QUERY, 8'd0, 4'd0, 16'h8000, 1'b1);
    send_item(FUNC_NONE, 8'hFF, 4'hF, 16'hFFFF, 1'b1);
    send_item(FUNC_CENTRE, 8'hFF, 4'hF, 16'h7FFF, 1'b1);
    send_item(FUNC_WIDTH, 8'hFF, 4'hF, 16'h0200, 1'b0);
    random_traffic(120);

    // A long receiver stall while queries keep coming fills the output
    // register and then holds off the input.
    start_phase(CFG_W'(3), 5'd2);
    hold_request = 1'b1;
    random_traffic(150);

    // Out-of-range register values clamp to one kernel and sixteen dimensions.
    // A tiny width gives a very large density, a huge one a very small density.
    start_phase(CFG_W'(0), 5'd31);
    for (int e = 0; e < MAX_DIM; e++) send_item(FUNC_CENTRE, 8'd0, 4'(e), 16'h0000, 1'b0);
    send_item(FUNC_WIDTH, 8'd0, 4'd0, 16'h0001, 1'b0);
    for (int e = 0; e < MAX_DIM; e++) query_item(4'(e), 16'h0000, e == MAX_DIM - 1);
    send_item(FUNC_WIDTH, 8'd0, 4'd0, 16'h7FFF, 1'b0);
    query_item(4'd15, 16'h0000, 1'b1);
    random_traffic(120);

    start_phase(CFG_W'(5), 5'd4);
    random_traffic(100);

    // Largest kernel count, reached through a clamped value. Most widths are
    // not positive so the walk stays short while every kernel is visited.
    start_phase(CFG_W'(511), 5'd0);
    for (int k = 0; k < MAX_KERNELS; k++) begin
      send_item(FUNC_WIDTH, 8'(k), 4'($urandom),
                (k % 16 == 0) ? width_value() : 16'(16'h8000 | $urandom), 1'b0);
    end
    random_traffic(120);

    start_phase(CFG_W'(2), 5'd16);
    random_traffic(100);

    start_phase(CFG_W'(256), 5'd3);
    for (int k = 0; k < MAX_KERNELS; k++) begin
      if (k >= 8 && sb.width[k] > 0) send_item(FUNC_WIDTH, 8'(k), 4'd0, 16'h0000, 1'b0);
    end
    start_phase(CFG_W'(8), 5'd3);
    random_traffic(120);

    drain();
    $display("Covered %0d items over %0d register settings: %0d densities checked,",
             items_sent, phases_run, sb.results_seen);
    $display("%0d of them zero and %0d saturated.", sb.zero_seen, sb.sat_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("ERROR: %0d mismatches, %0d results never arrived", sb.errors,
               sb.pending_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
